>>> hdl/rgb_to_hsl_converter_assert.svh
// Assertion macros for the RGB to HSL converter.
`ifndef RGB_TO_HSL_CONVERTER_ASSERT_SVH
`define RGB_TO_HSL_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RTH_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rth assertion failed");

// Next-cycle implication, checked outside reset.
`define RTH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rth assertion failed");

`endif

>>> hdl/rth_pkg.sv
// Shared constants and types for the RGB to HSL converter.
`timescale 1ns / 1ps
package rth_pkg;
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int PCT_FULL         = 100;
    localparam int PCT_HALF         = 50;
    localparam int PCT_SUM_FULL     = 200;
    localparam int HUE_STEP         = 60;
    localparam int HUE_GREEN        = 120;
    localparam int HUE_BLUE         = 240;
    localparam int HUE_FULL         = 360;
    localparam int DIV_QB           = 7;

    typedef logic [1:0] t_sect;
    localparam t_sect SECT_RED   = 2'd0;
    localparam t_sect SECT_GREEN = 2'd1;
    localparam t_sect SECT_BLUE  = 2'd2;
endpackage

>>> hdl/rgb_to_hsl_converter.sv
// RGB to HSL converter top level: scaling, sector logic and output stage.
// Fully pipelined: one word in and one word out per cycle while the output is taken.
// The pipeline is two 7-stage restoring dividers (channel scaling, then hue and
// saturation) plus four register stages around them. When the output word is not taken
// the whole pipeline holds and s_axis_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "rgb_to_hsl_converter_assert.svh"
module rgb_to_hsl_converter #(
    parameter int CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // red_count, green_count, blue_count, clear_count
    input  logic [((4*CHANNEL_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // hue_degrees, saturation_pct, lightness_pct, clamped_flag, zero_clear_error
    output logic [31:0] m_axis_tdata
);
    import rth_pkg::*;

    localparam int CB  = CHANNEL_BITS;
    localparam int NW1 = CB + DIV_QB;

    logic w_en;
    assign w_en          = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = w_en;

    // stage 1: count * 100
    logic           r1_vld;
    logic [NW1-1:0] r1_num [3];
    logic [CB-1:0]  r1_den;
    logic           r1_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_num[i] <= NW1'(s_axis_tdata[i*CB +: CB]) * NW1'(PCT_FULL);
            end
            r1_den  <= s_axis_tdata[3*CB +: CB];
            r1_zero <= s_axis_tdata[3*CB +: CB] == '0;
        end
    end

    logic [CB-1:0] w_den1 [3];
    logic [3:0]    w_side1;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_den1[i]  = r1_den;
            w_side1[i] = r1_num[i] >= (NW1'(r1_den) << DIV_QB);
        end
        w_side1[3] = r1_zero;
    end

    logic              d1_vld;
    logic [DIV_QB-1:0] d1_quo [3];
    logic [3:0]        d1_side;

    rth_div #(.LANES(3), .NW(NW1), .DW(CB), .QB(DIV_QB), .PW(4)) u_div_pct (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_vld),
        .i_num   (r1_num),
        .i_den   (w_den1),
        .i_side  (w_side1),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // stage 2: clamp to 100
    logic       r2_vld;
    logic [6:0] r2_pct [3];
    logic       r2_clamp;
    logic       r2_zero;
    logic [2:0] w_big;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_big[i] = d1_side[i] || (d1_quo[i] > 7'(PCT_FULL));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r2_pct[i] <= w_big[i] ? 7'(PCT_FULL) : d1_quo[i];
            end
            r2_clamp <= |w_big;
            r2_zero  <= d1_side[3];
        end
    end

    // stage 3: max, min, sector, divide operands
    t_sect      w_sect;
    logic [6:0] w_mx, w_mn, w_a, w_c, w_mag, w_dif, w_light;
    logic [7:0] w_sum, w_sden;
    logic       w_neg;

    always_comb begin
        if (r2_pct[0] >= r2_pct[1] && r2_pct[0] >= r2_pct[2]) begin
            w_sect = SECT_RED;
        end else if (r2_pct[1] >= r2_pct[2]) begin
            w_sect = SECT_GREEN;
        end else begin
            w_sect = SECT_BLUE;
        end
        unique case (w_sect)
            SECT_RED: begin
                w_mx = r2_pct[0];
                w_a  = r2_pct[1];
                w_c  = r2_pct[2];
            end
            SECT_GREEN: begin
                w_mx = r2_pct[1];
                w_a  = r2_pct[2];
                w_c  = r2_pct[0];
            end
            default: begin
                w_mx = r2_pct[2];
                w_a  = r2_pct[0];
                w_c  = r2_pct[1];
            end
        endcase
        w_mn    = (w_a < w_c) ? w_a : w_c;
        w_neg   = w_a < w_c;
        w_mag   = w_neg ? (w_c - w_a) : (w_a - w_c);
        w_dif   = w_mx - w_mn;
        w_sum   = {1'b0, w_mx} + {1'b0, w_mn};
        w_light = w_sum[7:1];
        w_sden  = (w_light <= 7'(PCT_HALF)) ? w_sum : (8'(PCT_SUM_FULL) - w_sum);
    end

    logic        r3_vld;
    logic [13:0] r3_num [2];
    logic [7:0]  r3_den [2];
    logic [12:0] r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_num[0] <= 14'(w_mag) * 14'(HUE_STEP);
            r3_den[0] <= {1'b0, w_dif};
            r3_num[1] <= 14'(w_dif) * 14'(PCT_FULL);
            r3_den[1] <= w_sden;
            r3_side   <= {w_sect, w_neg, w_light, r2_clamp, r2_zero, w_dif == '0};
        end
    end

    logic              d2_vld;
    logic [DIV_QB-1:0] d2_quo [2];
    logic [12:0]       d2_side;

    rth_div #(.LANES(2), .NW(14), .DW(8), .QB(DIV_QB), .PW(13)) u_div_hs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_vld),
        .i_num   (r3_num),
        .i_den   (r3_den),
        .i_side  (r3_side),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // stage 4: hue offset and output register
    t_sect      w_osect;
    logic       w_oneg, w_oclamp, w_ozero, w_ogrey;
    logic [6:0] w_olight;
    logic [8:0] w_q, w_hue;

    always_comb begin
        {w_osect, w_oneg, w_olight, w_oclamp, w_ozero, w_ogrey} = d2_side;
        w_q = 9'(d2_quo[0]);
        unique case (w_osect)
            SECT_RED:   w_hue = w_oneg ? (9'(HUE_FULL) - w_q) : w_q;
            SECT_GREEN: w_hue = w_oneg ? (9'(HUE_GREEN) - w_q) : (9'(HUE_GREEN) + w_q);
            default:    w_hue = w_oneg ? (9'(HUE_BLUE) - w_q) : (9'(HUE_BLUE) + w_q);
        endcase
    end

    logic       r_out_vld;
    logic [8:0] r_hue;
    logic [6:0] r_sat, r_light;
    logic       r_clamp, r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hue   <= (w_ozero || w_ogrey) ? '0 : w_hue;
            r_sat   <= (w_ozero || w_ogrey) ? '0 : d2_quo[1];
            r_light <= w_ozero ? '0 : w_olight;
            r_clamp <= w_ozero ? 1'b0 : w_oclamp;
            r_err   <= w_ozero;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'b0, r_err, r_clamp, r_light, r_sat, r_hue};

    `RTH_ASSERT_IMPL(a_err_zero, m_axis_tvalid && r_err, r_hue == '0 && r_sat == '0 && r_light == '0 && !r_clamp)
    `RTH_ASSERT_IMPL(a_range, m_axis_tvalid, r_hue <= 9'(HUE_FULL) && r_sat <= 7'(PCT_FULL) && r_light <= 7'(PCT_FULL))
    `RTH_ASSERT_IMPL(a_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `RTH_ASSERT_NEXT(a_enter, s_axis_tvalid && s_axis_tready, r1_vld)
endmodule

>>> hdl/rth_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
`timescale 1ns / 1ps
module rth_div #(
    parameter int LANES = 3,
    parameter int NW    = 23,
    parameter int DW    = 16,
    parameter int QB    = 7,
    parameter int PW    = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num  [LANES],
    input  logic [DW-1:0] i_den  [LANES],
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [QB-1:0] o_quo  [LANES],
    output logic [PW-1:0] o_side
);
    localparam int RW = DW + QB;

    logic [QB-1:0] r_vld;
    logic [RW-1:0] r_rem  [QB][LANES];
    logic [DW-1:0] r_den  [QB][LANES];
    logic [QB-1:0] r_quo  [QB][LANES];
    logic [PW-1:0] r_side [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [RW-1:0] w_rem [LANES];
        logic [DW-1:0] w_den [LANES];
        logic [QB-1:0] w_quo [LANES];
        logic [RW-1:0] w_sub [LANES];
        logic          w_ge  [LANES];
        logic [PW-1:0] w_side;
        logic          w_vld;

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    w_rem[l] = RW'(i_num[l]);
                    w_den[l] = i_den[l];
                    w_quo[l] = '0;
                end
                w_side = i_side;
                w_vld  = i_valid;
            end
        end else begin : g_next
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    w_rem[l] = r_rem[k-1][l];
                    w_den[l] = r_den[k-1][l];
                    w_quo[l] = r_quo[k-1][l];
                end
                w_side = r_side[k-1];
                w_vld  = r_vld[k-1];
            end
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_sub[l] = RW'(w_den[l]) << (QB - 1 - k);
                w_ge[l]  = w_rem[l] >= w_sub[l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < LANES; l++) begin
                    r_rem[k][l] <= w_ge[l] ? (w_rem[l] - w_sub[l]) : w_rem[l];
                    r_den[k][l] <= w_den[l];
                    r_quo[k][l] <= {w_quo[l][QB-2:0], w_ge[l]};
                end
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[QB-1];
    assign o_side  = r_side[QB-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_quo[QB-1][l];
        end
    end
endmodule

>>> tb/rgb_to_hsl_converter_checker.sv
// Checker for the RGB to HSL converter: watches both streams, predicts and compares.
`timescale 1ns / 1ps
module rgb_to_hsl_converter_checker #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [((4*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          o_errors,
    output int          o_pending
);
    import rth_pkg::*;

    typedef struct packed {
        logic       zero_clear_error;
        logic       clamped_flag;
        logic [6:0] lightness_pct;
        logic [6:0] saturation_pct;
        logic [8:0] hue_degrees;
    } t_hsl;

    t_hsl hsl_queue[$];
    int   mismatches = 0;

    assign o_errors  = mismatches;
    assign o_pending = hsl_queue.size();

    function automatic int scale_pct(int cnt, int clr, inout bit clamp);
        int p;
        p = (cnt * PCT_FULL) / clr;
        if (p > PCT_FULL) begin
            clamp = 1;
            p = PCT_FULL;
        end
        return p;
    endfunction

    function automatic t_hsl predict_hsl(logic [CHANNEL_BITS-1:0] rc, logic [CHANNEL_BITS-1:0] gc,
                                         logic [CHANNEL_BITS-1:0] bc, logic [CHANNEL_BITS-1:0] cc);
        t_hsl res;
        bit   clamp;
        int   r, g, b, mx, mn, dif, hue, sat, light;
        res = '0;
        clamp = 0;
        hue = 0;
        sat = 0;
        if (cc == 0) begin
            res.zero_clear_error = 1'b1;
            return res;
        end
        r = scale_pct(int'(rc), int'(cc), clamp);
        g = scale_pct(int'(gc), int'(cc), clamp);
        b = scale_pct(int'(bc), int'(cc), clamp);
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dif = mx - mn;
        light = (mx + mn) / 2;
        if (dif != 0) begin
            if (mx == r) begin
                hue = (HUE_STEP * (g - b)) / dif;
                if (g < b) hue += HUE_FULL;
            end else if (mx == g) begin
                hue = (HUE_STEP * (b - r)) / dif + HUE_GREEN;
            end else begin
                hue = (HUE_STEP * (r - g)) / dif + HUE_BLUE;
            end
            if (light <= PCT_HALF) sat = (dif * PCT_FULL) / (mx + mn);
            else sat = (dif * PCT_FULL) / (PCT_SUM_FULL - (mx + mn));
        end
        res.hue_degrees    = hue[8:0];
        res.saturation_pct = sat[6:0];
        res.lightness_pct  = light[6:0];
        res.clamped_flag   = clamp;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_hsl want, got;
        if (i_rst_n && s_tvalid && s_tready)
            hsl_queue.push_back(predict_hsl(s_tdata[CHANNEL_BITS-1:0],
                s_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS], s_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS],
                s_tdata[4*CHANNEL_BITS-1:3*CHANNEL_BITS]));
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[24:0];
            if (hsl_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output word %h", m_tdata);
            end else begin
                want = hsl_queue.pop_front();
                if (got !== want || m_tdata[31:25] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp h=%0d s=%0d l=%0d c=%b z=%b, got h=%0d s=%0d l=%0d c=%b z=%b",
                            want.hue_degrees, want.saturation_pct, want.lightness_pct,
                            want.clamped_flag, want.zero_clear_error,
                            got.hue_degrees, got.saturation_pct, got.lightness_pct,
                            got.clamped_flag, got.zero_clear_error);
                end
            end
        end
    end
endmodule

>>> tb/rgb_to_hsl_converter_tb.sv
// Testbench top for the RGB to HSL converter: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module rgb_to_hsl_converter_tb;
    localparam int CB = 16;
    localparam int NUM_RANDOM = 930;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    int          errors, pending;
    int          send_idle = 0, recv_stall = 0;
    bit          hold_off = 0;
    int          sent = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    rgb_to_hsl_converter #(.CHANNEL_BITS(CB)) dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    rgb_to_hsl_converter_checker #(.CHANNEL_BITS(CB)) chk (
        .i_clk, .i_rst_n, .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .m_tdata(m_axis_tdata), .o_errors(errors), .o_pending(pending)
    );

    // receiver
    always @(negedge i_clk) begin
        if (hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    // called and returns at a falling edge; valid drops and rises in one step back to back
    task automatic send_word(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic [15:0] c);
        while ($urandom_range(99) < send_idle) @(negedge i_clk);
        s_axis_tdata  = {c, b, g, r};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic logic [15:0] rand_chan(int mode);
        case (mode)
            0: return 16'($urandom_range(255));
            1: return 16'($urandom);
            default: return 16'($urandom_range(1000));
        endcase
    endfunction

    task automatic send_random();
        logic [15:0] r, g, b, c;
        int mode;
        mode = $urandom_range(9);
        if (mode < 6) begin
            c = 16'($urandom_range(1, 1000));
            r = 16'($urandom_range(0, c + c / 4));
            g = 16'($urandom_range(0, c + c / 4));
            b = 16'($urandom_range(0, c + c / 4));
            if ($urandom_range(7) == 0) g = r;
            if ($urandom_range(7) == 0) b = g;
        end else if (mode < 9) begin
            r = rand_chan(1); g = rand_chan(1); b = rand_chan(1); c = rand_chan(1);
        end else begin
            r = rand_chan(0); g = rand_chan(0); b = rand_chan(0);
            c = ($urandom_range(3) == 0) ? 16'd0 : rand_chan(0);
        end
        send_word(r, g, b, c);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        #100000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed
        send_word(0, 0, 0, 0);
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        send_word(0, 0, 0, 16'hFFFF);
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(16'hFFFF, 0, 0, 1);
        send_word(100, 0, 0, 100);
        send_word(0, 100, 0, 100);
        send_word(0, 0, 100, 100);
        send_word(100, 100, 0, 100);
        send_word(0, 100, 100, 100);
        send_word(100, 0, 100, 100);
        send_word(100, 100, 100, 100);
        send_word(50, 50, 50, 100);
        send_word(80, 40, 41, 100);
        send_word(80, 40, 80, 100);
        send_word(20, 60, 10, 100);
        send_word(10, 20, 90, 100);
        send_word(90, 80, 70, 100);
        send_word(30, 10, 5, 100);
        send_word(16'hAAAA, 16'h5555, 16'h1234, 16'hEDCB);
        send_word(16'h5555, 16'hAAAA, 16'hEDCB, 16'h8000);
        send_word(200, 150, 300, 100);
        drain();
        // pressure: long receiver hold-off while offering words
        hold_off = 1;
        fork
            begin
                repeat (20) send_random();
            end
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
        join
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 52; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 52; end
                default: begin send_idle = 17; recv_stall = 17; end
            endcase
            for (int i = 0; i < NUM_RANDOM / 4; i++) begin
                send_random();
                if (i % 60 == 59) begin
                    send_idle = (ph == 1 || ph == 3) ? send_idle : 0;
                    repeat ($urandom_range(20)) @(negedge i_clk);
                end
            end
            drain();
        end
        send_idle = 0;
        recv_stall = 0;
        drain();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d samples through four idling phases plus a long output hold-off.", sent);
        $display("Covered zero clear, clamping, grey, ties and all hue sectors.");
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hdl
hdl/rth_pkg.sv
hdl/rth_div.sv
hdl/rgb_to_hsl_converter.sv
tb/rgb_to_hsl_converter_checker.sv
tb/rgb_to_hsl_converter_tb.sv
